@@ rtl/rfa_pkg.sv @@
// Shared widths, constants and types of the radial falloff alpha pipeline.
package rfa_pkg;

  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int MAX_SIZE   = 4096;
  localparam int SIZE_RESET = 256;
  localparam int ALPHA_W    = 8;

  localparam int DIFF_W = SIZE_W;
  localparam int NUM_W  = 2 * DIFF_W;
  localparam int QUO_W  = 33;
  localparam int ROOT_W = 17;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 4;
  localparam int FRAC_W = 16;
  localparam int MUL_STAGES = 3;

  localparam logic [SIZE_W-1:0]  SIZE_MAX_C = SIZE_W'(MAX_SIZE);
  localparam logic [SIZE_W-1:0]  SIZE_RST_C = SIZE_W'(SIZE_RESET);
  localparam logic [ROOT_W-1:0]  ONE_Q16    = ROOT_W'(1 << FRAC_W);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX  = '1;

  typedef struct packed {
    logic valid;
    logic outside;
  } rfa_tag_t;

endpackage

@@ rtl/rfa_div.sv @@
// Pipelined restoring divider giving floor(num * 2^32 / den), one quotient bit per stage.
module rfa_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  rfa_pkg::rfa_tag_t        in_tag,
  input  logic [rfa_pkg::NUM_W-1:0] in_num,
  input  logic [rfa_pkg::NUM_W-1:0] in_den,
  output rfa_pkg::rfa_tag_t        out_tag,
  output logic [rfa_pkg::QUO_W-1:0] out_quo
);
  import rfa_pkg::*;

  rfa_tag_t         tag_r [QUO_W];
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [NUM_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  genvar k;
  generate
    for (k = 0; k < QUO_W; k++) begin : g_stage
      rfa_tag_t         tag_in;
      logic [NUM_W-1:0] rem_in;
      logic [NUM_W-1:0] den_in;
      logic [QUO_W-1:0] quo_in;
      logic [NUM_W:0]   shl;
      logic [NUM_W:0]   diff;
      logic             ge;
      logic [NUM_W-1:0] rem_nxt;

      if (k == 0) begin : g_first
        assign tag_in = in_tag;
        assign rem_in = in_num;
        assign den_in = in_den;
        assign quo_in = '0;
        assign shl    = {1'b0, rem_in};
      end else begin : g_next
        assign tag_in = tag_r[k-1];
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
        assign quo_in = quo_r[k-1];
        assign shl    = {rem_in, 1'b0};
      end

      assign diff    = shl - {1'b0, den_in};
      assign ge      = (shl >= {1'b0, den_in});
      assign rem_nxt = ge ? diff[NUM_W-1:0] : shl[NUM_W-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[k] <= '0;
        end else if (en) begin
          tag_r[k] <= tag_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
          quo_r[k] <= {quo_in[QUO_W-2:0], ge};
        end
      end
    end
  endgenerate

  assign out_tag = tag_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];

endmodule

@@ rtl/rfa_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
module rfa_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rfa_pkg::rfa_tag_t         in_tag,
  input  logic [rfa_pkg::QUO_W-1:0]  in_rad,
  output rfa_pkg::rfa_tag_t         out_tag,
  output logic [rfa_pkg::ROOT_W-1:0] out_root
);
  import rfa_pkg::*;

  rfa_tag_t          tag_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      rfa_tag_t          tag_in;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (i == 0) begin : g_first
        assign tag_in  = in_tag;
        assign rad_in  = {{(RAD_W-QUO_W){1'b0}}, in_rad};
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign tag_in  = tag_r[i-1];
        assign rad_in  = rad_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
      end

      assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
      assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[i] <= '0;
        end else if (en) begin
          tag_r[i] <= tag_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[i]  <= {rad_in[RAD_W-3:0], 2'b00};
          rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[i] <= {root_in[ROOT_W-2:0], ge};
        end
      end
    end
  endgenerate

  assign out_tag  = tag_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];

endmodule

@@ rtl/radial_falloff_alpha.sv @@
// Top level of the radial glow sprite alpha generator.
// Usage:
// The input channel takes one pixel coordinate per beat (in_pixel_x, in_pixel_y).
// The result channel gives one beat per input: out_alpha and out_outside.
// Both channels use valid and stall; a beat moves when valid is high and stall is low.
// cfg_we writes cfg_wdata into the image size register; write it only while idle.
// Sizes above 4096 act as 4096, and a pixel at or beyond the size is flagged outside.
// A beat passes through three setup stages, a 33-stage divider, a 17-stage square root,
// one subtract stage, three squaring multiplier stages and the output register.
// Throughput is one beat per clock while out_stall stays low.
// When a result waits under out_stall the whole pipeline holds and in_stall rises
// in the same cycle; no beat is lost or repeated.
// When the output register is empty the pipeline keeps moving even under out_stall.
// Synchronous reset clears all valid bits and sets the image size to 256.
module radial_falloff_alpha (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rfa_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rfa_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [rfa_pkg::COORD_W-1:0]  in_pixel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rfa_pkg::ALPHA_W-1:0]  out_alpha,
  output logic                         out_outside
);
  import rfa_pkg::*;

  logic en;

  logic [SIZE_W-1:0]  image_size_r;
  logic [SIZE_W-1:0]  size_eff;
  logic [SIZE_W-1:0]  x2;
  logic [SIZE_W-1:0]  y2;
  logic               outside_nxt;

  rfa_tag_t           a_tag_r;
  logic [DIFF_W-1:0]  dx_r;
  logic [DIFF_W-1:0]  dy_r;
  logic [SIZE_W-1:0]  size_r;

  rfa_tag_t           b_tag_r;
  logic [NUM_W-1:0]   dxx_r;
  logic [NUM_W-1:0]   dyy_r;
  logic [NUM_W-1:0]   ss_r;

  rfa_tag_t           c_tag_r;
  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   den_r;
  logic [NUM_W:0]     num_sum;

  rfa_tag_t           div_tag;
  logic [QUO_W-1:0]   quo;
  rfa_tag_t           sq_tag;
  logic [ROOT_W-1:0]  root;

  rfa_tag_t           m_tag_r [MUL_STAGES+1];
  logic [ROOT_W-1:0]  pw_r    [MUL_STAGES+1];

  logic [ALPHA_W+ROOT_W-1:0] scaled;
  logic [ALPHA_W-1:0]        alpha_nxt;

  logic               out_valid_r;
  logic [ALPHA_W-1:0] out_alpha_r;
  logic               out_outside_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= SIZE_RST_C;
    end else if (cfg_we) begin
      image_size_r <= cfg_wdata;
    end
  end

  assign size_eff    = (image_size_r > SIZE_MAX_C) ? SIZE_MAX_C : image_size_r;
  assign x2          = {in_pixel_x, 1'b0};
  assign y2          = {in_pixel_y, 1'b0};
  assign outside_nxt = ({1'b0, in_pixel_x} >= size_eff) || ({1'b0, in_pixel_y} >= size_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
      b_tag_r <= '0;
      c_tag_r <= '0;
    end else if (en) begin
      a_tag_r <= '{valid: in_valid, outside: outside_nxt};
      b_tag_r <= a_tag_r;
      c_tag_r <= b_tag_r;
    end
  end

  assign num_sum = {1'b0, dxx_r} + {1'b0, dyy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= (x2 >= size_eff) ? (x2 - size_eff) : (size_eff - x2);
      dy_r   <= (y2 >= size_eff) ? (y2 - size_eff) : (size_eff - y2);
      size_r <= size_eff;
      dxx_r  <= dx_r * dx_r;
      dyy_r  <= dy_r * dy_r;
      ss_r   <= size_r * size_r;
      num_r  <= num_sum[NUM_W-1:0];
      den_r  <= {ss_r[NUM_W-2:0], 1'b0};
    end
  end

  rfa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_tag  (c_tag_r),
    .in_num  (num_r),
    .in_den  (den_r),
    .out_tag (div_tag),
    .out_quo (quo)
  );

  rfa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_tag   (div_tag),
    .in_rad   (quo),
    .out_tag  (sq_tag),
    .out_root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r[0] <= '0;
    end else if (en) begin
      m_tag_r[0] <= sq_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r[0] <= ONE_Q16 - root;
    end
  end

  genvar m;
  generate
    for (m = 0; m < MUL_STAGES; m++) begin : g_square
      logic [2*ROOT_W-1:0] prod;

      assign prod = pw_r[m] * pw_r[m];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          m_tag_r[m+1] <= '0;
        end else if (en) begin
          m_tag_r[m+1] <= m_tag_r[m];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          pw_r[m+1] <= prod[FRAC_W+ROOT_W-1:FRAC_W];
        end
      end
    end
  endgenerate

  assign scaled = {pw_r[MUL_STAGES], {ALPHA_W{1'b0}}}
                - {{ALPHA_W{1'b0}}, pw_r[MUL_STAGES]};

  always_comb begin
    if (m_tag_r[MUL_STAGES].outside) begin
      alpha_nxt = '0;
    end else if (scaled[ALPHA_W+ROOT_W-1:ALPHA_W+FRAC_W] != '0) begin
      alpha_nxt = ALPHA_MAX;
    end else begin
      alpha_nxt = scaled[ALPHA_W+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_tag_r[MUL_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alpha_r   <= alpha_nxt;
      out_outside_r <= m_tag_r[MUL_STAGES].outside;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_alpha   = out_alpha_r;
  assign out_outside = out_outside_r;

endmodule

@@ test/tb_radial_falloff_alpha.sv @@
// Testbench for the radial falloff alpha generator: directed and random pixels against a predictor.
`timescale 1ns / 100ps

module tb_radial_falloff_alpha;
  import rfa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 70;

  typedef struct {
    logic [ALPHA_W-1:0] alpha;
    logic               outside;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } glow_pixel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [SIZE_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] in_pixel_x = '0;
  logic [COORD_W-1:0] in_pixel_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ALPHA_W-1:0] out_alpha;
  logic               out_outside;

  glow_pixel_t       glow_q[$];
  logic [SIZE_W-1:0] glow_size = SIZE_RST_C;
  int                error_count = 0;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                idle_en = 1'b1;
  bit                stall_en = 1'b1;
  int                hold_cycles = 0;

  radial_falloff_alpha i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_alpha  (out_alpha),
    .out_outside(out_outside)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic glow_pixel_t falloff_alpha(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y);
    glow_pixel_t p;
    logic [63:0] sz, px, py, dx, dy, num, den, q, t, u, u2, u4, u8, a;
    p.x = x;
    p.y = y;
    sz = 64'(glow_size);
    if (sz > MAX_SIZE) sz = MAX_SIZE;
    px = 64'(x);
    py = 64'(y);
    if (px >= sz || py >= sz) begin
      p.alpha = '0;
      p.outside = 1'b1;
      return p;
    end
    dx = (2 * px >= sz) ? 2 * px - sz : sz - 2 * px;
    dy = (2 * py >= sz) ? 2 * py - sz : sz - 2 * py;
    num = dx * dx + dy * dy;
    den = 2 * sz * sz;
    q = (num << 32) / den;
    t = floor_root(q);
    if (t > 65536) t = 65536;
    u = 65536 - t;
    u2 = (u * u) >> 16;
    u4 = (u2 * u2) >> 16;
    u8 = (u4 * u4) >> 16;
    a = (u8 * 255) >> 16;
    if (a > 255) a = 255;
    p.alpha = a[ALPHA_W-1:0];
    p.outside = 1'b0;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int eff;
    eff = (glow_size > MAX_SIZE) ? MAX_SIZE : int'(glow_size);
    if (eff == 0 || $urandom_range(0, 4) == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, eff - 1));
  endfunction

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = idle_en ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    glow_q.push_back(falloff_alpha(x, y));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic load_size(input logic [SIZE_W-1:0] value);
    while (glow_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    glow_size = value;
  endtask

  task automatic test_reset_size();
    send_pixel(12'd128, 12'd128);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd255, 12'd0);
    send_pixel(12'd0, 12'd255);
    send_pixel(12'd255, 12'd255);
    send_pixel(12'd255, 12'd128);
    send_pixel(12'd256, 12'd0);
    send_pixel(12'd0, 12'd256);
    send_pixel(12'd4095, 12'd4095);
    stop_sending();
  endtask

  task automatic test_small_sizes();
    load_size(13'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    stop_sending();
    load_size(13'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    stop_sending();
    load_size(13'd3);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd0);
    stop_sending();
  endtask

  task automatic test_largest_sizes();
    load_size(13'(MAX_SIZE));
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    stop_sending();
    load_size(13'h1FFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2047);
    stop_sending();
  endtask

  task automatic test_random_sizes();
    logic [SIZE_W-1:0] sz;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0: sz = SIZE_W'($urandom_range(1, 8));
        1: sz = SIZE_W'($urandom_range(MAX_SIZE + 1, 8191));
        2: sz = '0;
        3: sz = SIZE_MAX_C;
        default: sz = SIZE_W'($urandom_range(1, MAX_SIZE));
      endcase
      load_size(sz);
      idle_en = (p % 3) != 2;
      stall_en = (p % 4) != 3;
      repeat (110) send_pixel(pick_coord(), pick_coord());
      stop_sending();
    end
  endtask

  task automatic test_output_backpressure();
    load_size(SIZE_W'($urandom_range(16, MAX_SIZE)));
    idle_en = 1'b0;
    stall_en = 1'b1;
    hold_cycles = 250;
    repeat (150) send_pixel(pick_coord(), pick_coord());
    stop_sending();
    idle_en = 1'b1;
  endtask

  initial begin : stall_pattern
    bit stall_phase;
    int phase_left;
    stall_phase = 1'b0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_en) begin
        if (phase_left == 0) begin
          stall_phase = !stall_phase;
          phase_left = stall_phase ? $urandom_range(1, 4) : $urandom_range(1, 8);
        end
        phase_left--;
        out_stall <= stall_phase;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    glow_pixel_t exp_pix;
    if (rst_n && out_valid && !out_stall) begin
      if (glow_q.size() == 0) begin
        $display("%0t: unexpected result alpha %0d outside %0b", $time, out_alpha,
                 out_outside);
        error_count++;
      end else begin
        exp_pix = glow_q.pop_front();
        if (out_alpha !== exp_pix.alpha) begin
          $display("%0t: alpha mismatch at (%0d,%0d) expected %0d actual %0d", $time,
                   exp_pix.x, exp_pix.y, exp_pix.alpha, out_alpha);
          error_count++;
        end
        if (out_outside !== exp_pix.outside) begin
          $display("%0t: outside mismatch at (%0d,%0d) expected %0b actual %0b", $time,
                   exp_pix.x, exp_pix.y, exp_pix.outside, out_outside);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, glow_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_small_sizes();
    test_largest_sizes();
    test_random_sizes();
    test_output_backpressure();
    while (glow_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
